>>> rtl/bswr_pkg.sv
// Shared constants, command and status codes, controller states and the
// storage request type for the bounded stack with reverse.
// No dependencies.
package bswr_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_REVERSE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_REV_W1,
        S_REV_W2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic [ADDR_W-1:0]     rd_addr_a;
        logic [ADDR_W-1:0]     rd_addr_b;
    } t_ram_req;

endpackage

>>> rtl/bswr_ram.sv
// Stack storage: one write port and two registered read ports.
// Depends on bswr_pkg for the depth, word width and request type.
module bswr_ram
    import bswr_pkg::*;
(
    input  logic                  i_clk,
    input  t_ram_req              i_req,
    output logic [DATA_WIDTH-1:0] o_rd_data_a,
    output logic [DATA_WIDTH-1:0] o_rd_data_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // A read of the entry being written in the same cycle returns the old word.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_req.rd_addr_a];
        r_rd_b <= r_mem[i_req.rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/bounded_stack_with_reverse.sv
// Top level of the bounded stack with reverse: command controller and result register.
// Depends on bswr_pkg and bswr_ram.
//
// A sixteen-entry LIFO of signed 32-bit words held in a RAM with one write port
// and two registered read ports. One command is handled at a time. A push, or
// any refused or trivial command, goes from acceptance straight to S_RESP and
// then to the result register; a successful pop or peek first passes S_READ,
// since it waits for the RAM read. A reverse of two or more elements runs one
// swap per S_REV_W1/S_REV_W2 pair: each swap reads both ends together and writes them back one after the other through
// the single write port. A result that is not taken holds the controller in its
// final state, so the next command waits until the result register is free.
// The stack count resets to zero; the RAM needs no clearing after reset.
module bounded_stack_with_reverse
    import bswr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_command,
    input  logic signed [VALUE_W-1:0] i_push_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_top_value,
    output logic [1:0]                o_status,
    output logic [CNT_W-1:0]          o_element_count,
    output logic                      o_is_empty
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_is_pop, n_is_pop;
    logic [ADDR_W-1:0]     r_lo, n_lo;
    logic [ADDR_W-1:0]     r_hi, n_hi;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    logic [VALUE_W-1:0]    r_res_top, n_res_top;
    t_status               r_res_status, n_res_status;

    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_out_top, n_out_top;
    t_status               r_out_status, n_out_status;
    logic [CNT_W-1:0]      r_out_count, n_out_count;
    logic                  r_out_empty, n_out_empty;

    t_ram_req              w_req;
    logic [DATA_WIDTH-1:0] w_rd_a;
    logic [DATA_WIDTH-1:0] w_rd_b;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_load_out;
    logic                  w_full;
    logic                  w_empty;
    logic [ADDR_W-1:0]     w_top_addr;
    logic [ADDR_W:0]       w_next_lo;
    logic [ADDR_W:0]       w_next_hi;
    logic                  w_more;
    t_cmd                  w_cmd;

    bswr_ram u_ram (
        .i_clk       (i_clk),
        .i_req       (w_req),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    assign w_cmd      = t_cmd'(i_command);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_top_addr = ADDR_W'(r_count - CNT_W'(1));
    assign w_next_lo  = {1'b0, r_lo} + (ADDR_W + 1)'(1);
    assign w_next_hi  = {1'b0, r_hi} - (ADDR_W + 1)'(1);
    assign w_more     = (w_next_lo < w_next_hi);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_PUSH:          n_state = S_RESP;
                        CMD_POP, CMD_PEEK: n_state = w_empty ? S_RESP : S_READ;
                        CMD_REVERSE: begin
                            n_state = (r_count >= CNT_W'(2)) ? S_REV_W1 : S_RESP;
                        end
                        default:           n_state = S_RESP;
                    endcase
                end
            end
            S_READ:   n_state = S_RESP;
            S_REV_W1: n_state = S_REV_W2;
            S_REV_W2: n_state = w_more ? S_REV_W1 : S_RESP;
            S_RESP:   n_state = w_out_free ? S_IDLE : S_RESP;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM requests and result loading.
    always_comb begin
        n_count      = r_count;
        n_is_pop     = r_is_pop;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_tmp        = r_tmp;
        n_res_top    = r_res_top;
        n_res_status = r_res_status;
        w_load_out   = 1'b0;
        w_req.wr_en     = 1'b0;
        w_req.wr_addr   = r_lo;
        w_req.wr_data   = w_rd_b;
        w_req.rd_addr_a = r_lo;
        w_req.rd_addr_b = r_hi;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_top    = '0;
                    n_res_status = ST_OK;
                    n_is_pop     = (w_cmd == CMD_POP);
                    unique case (w_cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_res_status = ST_OVERFLOW;
                            end else begin
                                w_req.wr_en   = 1'b1;
                                w_req.wr_addr = ADDR_W'(r_count);
                                w_req.wr_data = i_push_value[DATA_WIDTH-1:0];
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (w_empty) begin
                                n_res_status = ST_UNDERFLOW;
                            end else begin
                                w_req.rd_addr_a = w_top_addr;
                            end
                        end
                        CMD_REVERSE: begin
                            n_lo            = '0;
                            n_hi            = w_top_addr;
                            w_req.rd_addr_a = '0;
                            w_req.rd_addr_b = w_top_addr;
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_top = VALUE_W'($signed(w_rd_a));
                if (r_is_pop) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_REV_W1: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_lo;
                w_req.wr_data = w_rd_b;
                n_tmp         = w_rd_a;
            end
            S_REV_W2: begin
                // The next pair never touches the entry written here, so the
                // reads can be issued in the same cycle.
                w_req.wr_en     = 1'b1;
                w_req.wr_addr   = r_hi;
                w_req.wr_data   = r_tmp;
                n_lo            = w_next_lo[ADDR_W-1:0];
                n_hi            = w_next_hi[ADDR_W-1:0];
                w_req.rd_addr_a = w_next_lo[ADDR_W-1:0];
                w_req.rd_addr_b = w_next_hi[ADDR_W-1:0];
            end
            S_RESP: begin
                w_load_out = w_out_free;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    // Result register.
    always_comb begin
        n_out_top    = r_out_top;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        if (w_load_out) begin
            n_out_valid  = 1'b1;
            n_out_top    = r_res_top;
            n_out_status = r_res_status;
            n_out_count  = r_count;
            n_out_empty  = (r_count == '0);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_pop     <= n_is_pop;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_tmp        <= n_tmp;
        r_res_top    <= n_res_top;
        r_res_status <= n_res_status;
        r_out_top    <= n_out_top;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
    end

    assign o_out_valid     = r_out_valid;
    assign o_top_value     = r_out_top;
    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;
    assign o_is_empty      = r_out_empty;

    // The count never runs past the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("stack count exceeds depth");

    // A push onto a stack with room adds exactly one element.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == CMD_PUSH && !w_full) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the stack by one");

    // The swap pointers stay ordered throughout a reverse.
    a_rev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REV_W1 || r_state == S_REV_W2) |-> r_lo < r_hi)
        else $error("reverse pointers crossed");

    // An underflow result carries no word.
    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNDERFLOW) |-> o_top_value == '0)
        else $error("underflow result carries a word");

endmodule

>>> tb/sv/stack_reply_checker.sv
// Reply checker for the bounded stack with reverse: keeps a shadow stack,
// predicts the reply to every accepted command and compares it with the block.
// Depends on bswr_pkg.
`timescale 1ns / 1ps
module stack_reply_checker
    import bswr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_command,
    input  logic signed [VALUE_W-1:0] i_push_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [VALUE_W-1:0] i_top_value,
    input  logic [1:0]                i_status,
    input  logic [CNT_W-1:0]          i_element_count,
    input  logic                      i_is_empty,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_reply_count,
    output int                        o_refused_pushes,
    output int                        o_empty_reads,
    output int                        o_deep_reverses
);

    typedef struct {
        logic signed [VALUE_W-1:0] top_value;
        t_status                   status;
        logic [CNT_W-1:0]          element_count;
        logic                      is_empty;
    } t_stack_reply;

    logic signed [DATA_WIDTH-1:0] shadow_words [DEPTH];
    int                           shadow_depth;
    t_stack_reply                 awaited_replies [$];

    // Applies one command to the shadow stack and returns the reply it earns.
    function automatic t_stack_reply apply_command(t_cmd cmd,
                                                   logic signed [VALUE_W-1:0] value);
        t_stack_reply                 reply;
        int                           lo;
        int                           hi;
        logic signed [DATA_WIDTH-1:0] held;
        reply.top_value = '0;
        reply.status    = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_depth >= DEPTH) begin
                    reply.status = ST_OVERFLOW;
                    o_refused_pushes++;
                end else begin
                    shadow_words[shadow_depth] = value[DATA_WIDTH-1:0];
                    shadow_depth++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (shadow_depth == 0) begin
                    reply.status = ST_UNDERFLOW;
                    o_empty_reads++;
                end else begin
                    // A narrower stored word is sign-extended on the way out.
                    reply.top_value = shadow_words[shadow_depth - 1];
                    if (cmd == CMD_POP) begin
                        shadow_depth--;
                    end
                end
            end
            default: begin
                if (shadow_depth >= 2) begin
                    o_deep_reverses++;
                end
                lo = 0;
                hi = shadow_depth - 1;
                while (lo < hi) begin
                    held             = shadow_words[lo];
                    shadow_words[lo] = shadow_words[hi];
                    shadow_words[hi] = held;
                    lo++;
                    hi--;
                end
            end
        endcase
        reply.element_count = CNT_W'(shadow_depth);
        reply.is_empty      = (shadow_depth == 0);
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_stack_reply want;
        if (!i_rst_n) begin
            shadow_depth     = 0;
            awaited_replies.delete();
            o_fail_count     = 0;
            o_reply_count    = 0;
            o_refused_pushes = 0;
            o_empty_reads    = 0;
            o_deep_reverses  = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                awaited_replies.push_back(apply_command(t_cmd'(i_command), i_push_value));
            end
            if (i_out_valid && i_out_ready) begin
                o_reply_count++;
                if (awaited_replies.size() == 0) begin
                    $error("Reply beat arrived with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, i_top_value);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, i_element_count);
                        o_fail_count++;
                    end
                    if (i_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d",
                               want.is_empty, i_is_empty);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the bounded stack with reverse testbench: clock, reset, command
// stimulus, receiver stalls and the verdict. Depends on bswr_pkg, the block
// and stack_reply_checker.
`timescale 1ns / 1ps
module tb_top
    import bswr_pkg::*;
();

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [1:0]                i_command;
    logic signed [VALUE_W-1:0] i_push_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [VALUE_W-1:0] o_top_value;
    logic [1:0]                o_status;
    logic [CNT_W-1:0]          o_element_count;
    logic                      o_is_empty;

    int fail_count;
    int pending_count;
    int reply_count;
    int refused_pushes;
    int empty_reads;
    int deep_reverses;
    int commands_sent;

    bounded_stack_with_reverse dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_push_value    (i_push_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_top_value     (o_top_value),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_is_empty      (o_is_empty)
    );

    stack_reply_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_push_value     (i_push_value),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_top_value      (o_top_value),
        .i_status         (o_status),
        .i_element_count  (o_element_count),
        .i_is_empty       (o_is_empty),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count),
        .o_reply_count    (reply_count),
        .o_refused_pushes (refused_pushes),
        .o_empty_reads    (empty_reads),
        .o_deep_reverses  (deep_reverses)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Offers one command and holds it until the block takes the beat.
    task automatic offer_command(t_cmd cmd, logic signed [VALUE_W-1:0] value);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        commands_sent++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Bias 0 fills the stack, bias 1 drains it, bias 2 wanders.
    function automatic t_cmd pick_command(int bias);
        int roll;
        int push_pct;
        int pop_pct;
        roll     = $urandom_range(0, 99);
        push_pct = (bias == 0) ? 65 : (bias == 1) ? 15 : 40;
        pop_pct  = (bias == 0) ? 15 : (bias == 1) ? 65 : 30;
        if (roll < push_pct) return CMD_PUSH;
        if (roll < push_pct + pop_pct) return CMD_POP;
        if (roll < 90) return CMD_PEEK;
        return CMD_REVERSE;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // The receiver changes its stall pattern from segment to segment and once,
    // well into the random part, holds off long enough to back the block up.
    initial begin : receiver
        int rx_cycle;
        int seg_kind;
        int seg_len;
        bit held_off;
        i_out_ready = 1'b0;
        rx_cycle    = 0;
        held_off    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(5, 80);
            if (!held_off && rx_cycle >= 3000) begin
                held_off = 1'b1;
                repeat (400) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                    rx_cycle++;
                end
            end
            repeat (seg_len) begin
                @(negedge i_clk);
                case (seg_kind)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                rx_cycle++;
            end
        end
    end

    initial begin : stimulus
        int burst_left;
        int bias;
        int bias_left;
        int waited;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_PUSH;
        i_push_value  = '0;
        commands_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: reads on an empty stack, reverses of one, two and a
        // full stack, the value extremes and a refused push.
        offer_command(CMD_POP, 32'sd5);
        offer_command(CMD_PEEK, 32'sd6);
        offer_command(CMD_PUSH, 32'sh7FFF_FFFF);
        offer_command(CMD_REVERSE, '0);
        offer_command(CMD_PUSH, 32'sh8000_0000);
        offer_command(CMD_REVERSE, '0);
        offer_command(CMD_POP, '0);
        for (int k = 0; k < 15; k++) begin
            offer_command(CMD_PUSH, (k % 2) ? -(k + 1) : k * 32'sh0123_4567);
        end
        offer_command(CMD_PUSH, -32'sd1);
        offer_command(CMD_REVERSE, '0);
        offer_command(CMD_POP, '0);

        burst_left = $urandom_range(1, 20);
        bias_left  = 0;
        bias       = 2;
        for (int n = 0; n < 2000; n++) begin
            if (bias_left == 0) begin
                bias      = $urandom_range(0, 2);
                bias_left = $urandom_range(10, 60);
            end
            bias_left--;
            offer_command(pick_command(bias), pick_value());
            burst_left--;
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 20);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (40) @(negedge i_clk);
        if (pending_count != 0) begin
            $error("%0d replies still outstanding at the end of the run", pending_count);
        end

        $display("Sent %0d commands and checked %0d replies.", commands_sent, reply_count);
        $display("Seen %0d refused pushes, %0d reads of an empty stack,",
                 refused_pushes, empty_reads);
        $display("and %0d reverses of two or more.", deep_reverses);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> bounded_stack_with_reverse.f
rtl/bswr_pkg.sv
rtl/bswr_ram.sv
rtl/bounded_stack_with_reverse.sv
tb/sv/stack_reply_checker.sv
tb/sv/tb_top.sv
